// File: design/ntm_pkg.sv
// ----------------------------------------------------------------------------
// ntm_pkg: shared types and constants of the nearest timestamp matcher
// Holds the beat payload structs, the state encoding, the mode codes and the
// sizes that follow from the frame store depth.
// ----------------------------------------------------------------------------
package ntm_pkg;

   // Frame store depth and the widths that follow from it.
   localparam int FRAME_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(FRAME_DEPTH);
   localparam int COUNT_W     = $clog2(FRAME_DEPTH + 1);

   // Fixed field widths.
   localparam int TIME_W   = 48;
   localparam int DIFF_W   = 30;
   localparam int NUMBER_W = 16;
   localparam int INDEX_W  = 12;
   localparam int MODE_W   = 2;

   // Running minimum starts at 1000 s, expressed in microseconds.
   localparam logic [DIFF_W-1:0]   DIFF_CAP_US   = DIFF_W'(1000 * 1000000);
   localparam logic [DIFF_W-1:0]   TOL_RESET_US  = DIFF_W'(2000);
   localparam logic [NUMBER_W-1:0] QCOUNT_MAX    = '1;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_APPEND  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [TIME_W-1:0] time_us;
   } ntm_req_type;

   typedef struct packed {
      logic [NUMBER_W-1:0] keyframe_number;
      logic [INDEX_W-1:0]  frame_index;
      logic [DIFF_W-1:0]   time_diff_us;
   } ntm_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } ntm_state_type;

   // Sequencer to compare unit.
   typedef struct packed {
      logic              start;
      logic              issue;
      logic [ADDR_W-1:0] idx;
      logic [TIME_W-1:0] key_time;
   } ntm_scan_ctl_type;

   // Compare unit back to sequencer.
   typedef struct packed {
      logic              busy;
      logic [DIFF_W-1:0] best_diff;
      logic [ADDR_W-1:0] best_idx;
   } ntm_scan_sts_type;

endpackage

// File: design/ntm_frame_ram.sv
// ----------------------------------------------------------------------------
// ntm_frame_ram: frame timestamp store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ntm_frame_ram
   import ntm_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [TIME_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [TIME_W-1:0] rd_data
);

   logic [TIME_W-1:0] mem [FRAME_DEPTH];
   logic [TIME_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ntm_diff_unit.sv
// ----------------------------------------------------------------------------
// ntm_diff_unit: shared absolute difference and running minimum unit
// Takes one stored time per cycle, forms its distance to the key time in one
// stage and folds it into the running minimum in the next.
// ----------------------------------------------------------------------------
module ntm_diff_unit
   import ntm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ntm_scan_ctl_type  ctl,
   input  logic [TIME_W-1:0] rd_data,
   output ntm_scan_sts_type  sts
);

   logic              rd_vld_ff,   rd_vld_in;
   logic [ADDR_W-1:0] rd_idx_ff,   rd_idx_in;
   logic              diff_vld_ff, diff_vld_in;
   logic [TIME_W-1:0] diff_ff,     diff_in;
   logic [ADDR_W-1:0] diff_idx_ff, diff_idx_in;
   logic [DIFF_W-1:0] best_ff,     best_in;
   logic [ADDR_W-1:0] best_idx_ff, best_idx_in;

   always_comb begin
      rd_vld_in   = ctl.issue;
      rd_idx_in   = ctl.idx;
      diff_vld_in = rd_vld_ff;
      diff_idx_in = rd_idx_ff;
      if (rd_data >= ctl.key_time) begin
         diff_in = rd_data - ctl.key_time;
      end else begin
         diff_in = ctl.key_time - rd_data;
      end

      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      if (ctl.start) begin
         best_in     = DIFF_CAP_US;
         best_idx_in = '0;
      end else if (diff_vld_ff && (diff_ff < TIME_W'(best_ff))) begin
         // The difference is below the cap here, so it fits the narrow field.
         best_in     = diff_ff[DIFF_W-1:0];
         best_idx_in = diff_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         diff_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= rd_vld_in;
         diff_vld_ff <= diff_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      diff_ff     <= diff_in;
      diff_idx_ff <= diff_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   assign sts.busy      = rd_vld_ff | diff_vld_ff;
   assign sts.best_diff = best_ff;
   assign sts.best_idx  = best_idx_ff;

endmodule

// File: design/ntm_ctrl.sv
// ----------------------------------------------------------------------------
// ntm_ctrl: request decode and scan sequencer
// Keeps the frame, search and keyframe counters, walks the store during a
// query and holds the response register.
// ----------------------------------------------------------------------------
module ntm_ctrl
   import ntm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ntm_req_type       req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ntm_rsp_type       rsp_payload,
   input  logic              csr_write_enable,
   input  logic [DIFF_W-1:0] csr_write_data,
   output logic              ram_wr_en,
   output logic [ADDR_W-1:0] ram_wr_addr,
   output logic [TIME_W-1:0] ram_wr_data,
   output logic [ADDR_W-1:0] ram_rd_addr,
   output ntm_scan_ctl_type  scan_ctl,
   input  ntm_scan_sts_type  scan_sts
);

   ntm_state_type       state_ff,        state_in;
   logic [COUNT_W-1:0]  frame_count_ff,  frame_count_in;
   logic [ADDR_W-1:0]   search_start_ff, search_start_in;
   logic [NUMBER_W-1:0] query_count_ff,  query_count_in;
   logic [NUMBER_W-1:0] number_ff,       number_in;
   logic [TIME_W-1:0]   key_time_ff,     key_time_in;
   logic [COUNT_W-1:0]  ptr_ff,          ptr_in;
   logic [DIFF_W-1:0]   tol_ff,          tol_in;
   logic                rsp_valid_ff,    rsp_valid_in;
   ntm_rsp_type         rsp_payload_ff,  rsp_payload_in;
   logic                match;

   assign match = scan_sts.best_diff < tol_ff;

   always_comb begin
      state_in        = state_ff;
      frame_count_in  = frame_count_ff;
      search_start_in = search_start_ff;
      query_count_in  = query_count_ff;
      number_in       = number_ff;
      key_time_in     = key_time_ff;
      ptr_in          = ptr_ff;
      tol_in          = csr_write_enable ? csr_write_data : tol_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_payload_in  = rsp_payload_ff;

      ram_wr_en         = 1'b0;
      ram_wr_addr       = frame_count_ff[ADDR_W-1:0];
      ram_wr_data       = req_payload.time_us;
      ram_rd_addr       = ptr_ff[ADDR_W-1:0];
      scan_ctl.start    = 1'b0;
      scan_ctl.issue    = 1'b0;
      scan_ctl.idx      = ptr_ff[ADDR_W-1:0];
      scan_ctl.key_time = key_time_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_payload.mode)
                  MODE_APPEND: begin
                     // Appends beyond the store depth are dropped.
                     if (frame_count_ff < COUNT_W'(FRAME_DEPTH)) begin
                        ram_wr_en      = 1'b1;
                        frame_count_in = frame_count_ff + 1'b1;
                     end
                  end
                  MODE_QUERY: begin
                     key_time_in = req_payload.time_us;
                     number_in   = query_count_ff;
                     if (query_count_ff != QCOUNT_MAX) begin
                        query_count_in = query_count_ff + 1'b1;
                     end
                     ptr_in         = COUNT_W'(search_start_ff);
                     scan_ctl.start = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  MODE_RESTART: begin
                     frame_count_in  = '0;
                     search_start_in = '0;
                     query_count_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (ptr_ff < frame_count_ff) begin
               scan_ctl.issue = 1'b1;
               ptr_in         = ptr_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!scan_sts.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!match) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_in) begin
               rsp_valid_in                   = 1'b1;
               rsp_payload_in.keyframe_number = number_ff;
               rsp_payload_in.frame_index     = INDEX_W'(scan_sts.best_idx);
               rsp_payload_in.time_diff_us    = scan_sts.best_diff;
               search_start_in                = scan_sts.best_idx;
               state_in                       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_count_ff  <= '0;
         search_start_ff <= '0;
         query_count_ff  <= '0;
         ptr_ff          <= '0;
         tol_ff          <= TOL_RESET_US;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         frame_count_ff  <= frame_count_in;
         search_start_ff <= search_start_in;
         query_count_ff  <= query_count_in;
         ptr_ff          <= ptr_in;
         tol_ff          <= tol_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      number_ff      <= number_in;
      key_time_ff    <= key_time_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: design/nearest_timestamp_matcher_top.sv
// ----------------------------------------------------------------------------
// nearest_timestamp_matcher_top: nearest frame timestamp matcher
// Stores frame times and, for each keyframe query, finds the stored frame
// nearest in time from the last match onward and reports it when it lies
// within the programmed tolerance.
// ----------------------------------------------------------------------------
//
//   Port group   Direction   Handshake          Beat contents
//   req_         in          valid / stall      mode, time_us
//   rsp_         out         valid / stall      keyframe_number, frame_index,
//                                               time_diff_us
//   csr_         in          write enable only  time_tolerance_us
//
// An append, restart or unused mode beat leaves the sequencer in ST_IDLE, so
// such beats can be accepted back to back. After a query beat, req_stall stays
// high while the sequencer passes through ST_SCAN, ST_DRAIN and ST_DONE; in
// ST_SCAN the store's single read port delivers one frame time per cycle, from
// the search start to the last stored frame, to the shared difference and
// compare unit. A matching result sits in the response register; a later
// query that matches waits at its end, with req_stall still high, until that
// register is free. Synchronous reset clears the counters, the tolerance (to
// 2000 us) and the response valid; the frame store itself is not cleared,
// since only entries written since the last restart are ever read.
//
module nearest_timestamp_matcher_top
   import ntm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ntm_req_type       req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ntm_rsp_type       rsp_payload,
   input  logic              csr_write_enable,
   input  logic [DIFF_W-1:0] csr_write_data
);

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [TIME_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [TIME_W-1:0] ram_rd_data;
   ntm_scan_ctl_type  scan_ctl;
   ntm_scan_sts_type  scan_sts;

   // Sequencer: decodes request beats, owns the counters and walks the store.
   ntm_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_addr      (ram_rd_addr),
      .scan_ctl         (scan_ctl),
      .scan_sts         (scan_sts)
   );

   // Frame time store with one write and one registered read per cycle.
   ntm_frame_ram u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Shared distance and minimum unit; a strict less-than keeps the earliest
   // frame on a tie.
   ntm_diff_unit u_diff_unit (
      .clock   (clock),
      .reset   (reset),
      .ctl     (scan_ctl),
      .rd_data (ram_rd_data),
      .sts     (scan_sts)
   );

endmodule
